### rtl/bwd_pkg.sv
// Shared types, constants and helpers for the boundary wave damping cell.
// No dependencies; every other file of the block imports this package.
package bwd_pkg;

  localparam int unsigned MASK_TABLE_DEPTH_DEF = 256;
  localparam int unsigned MASK_W = 10;

  localparam longint unsigned HALF_PI_Q30 = 64'd1686629713;
  localparam longint unsigned ONE_Q30     = 64'd1073741824;
  localparam longint unsigned BETA_Q32    = 64'd34359738;

  localparam longint unsigned TAYLOR_DIV [8] = '{64'd1, 64'd6, 64'd20, 64'd42,
                                                 64'd72, 64'd110, 64'd156, 64'd210};

  localparam logic signed [31:0] Y_LOWER_RST     = 32'sd0;
  localparam logic signed [31:0] Y_UPPER_RST     = 32'sd65536;
  localparam logic        [30:0] ZONE_W_RST      = 31'd6554;
  localparam logic        [30:0] INV_ZONE_W_RST  = 31'd655360;
  localparam logic signed [31:0] DENSITY_REF_RST = 32'sd65536;
  localparam logic signed [31:0] ENERGY_REF_RST  = 32'sd65536;

  typedef enum logic [2:0] {
    CFG_Y_LOWER     = 3'd0,
    CFG_Y_UPPER     = 3'd1,
    CFG_ZONE_W      = 3'd2,
    CFG_INV_ZONE_W  = 3'd3,
    CFG_DENSITY_REF = 3'd4,
    CFG_ENERGY_REF  = 3'd5
  } cfg_idx_e;

  typedef enum logic [1:0] {
    ZONE_NONE  = 2'd0,
    ZONE_LOWER = 2'd1,
    ZONE_UPPER = 2'd2
  } zone_e;

  typedef struct packed {
    logic signed [31:0] vx;
    logic signed [31:0] vy;
    logic signed [31:0] en;
    logic signed [31:0] rho;
    logic signed [32:0] vx_ref;
    zone_e              zone;
  } cell_t;

  function automatic logic signed [31:0] sat32(input logic signed [47:0] v);
    if (v > 48'sd2147483647) begin
      return 32'sh7fffffff;
    end else if (v < -48'sd2147483648) begin
      return 32'sh80000000;
    end
    return v[31:0];
  endfunction

endpackage

### rtl/bwd_zone.sv
// Zone classification stage: zone tests, distance and x velocity reference.
// Depends on bwd_pkg.
module bwd_zone import bwd_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               valid_i,
  input  logic signed [31:0] y_center_i,
  input  logic signed [31:0] y_low_edge_i,
  input  logic signed [31:0] vel_x_i,
  input  logic signed [31:0] vel_y_i,
  input  logic signed [31:0] energy_in_i,
  input  logic signed [31:0] density_in_i,
  input  logic signed [31:0] y_lower_i,
  input  logic signed [31:0] y_upper_i,
  input  logic        [30:0] zone_width_i,
  output logic               valid_o,
  output logic signed [31:0] dist_o,
  output cell_t              cell_o
);

  logic signed [33:0] lo_dist, up_lim, zw;
  logic signed [34:0] d_lo, neg3y;
  logic signed [33:0] d_up;
  logic               valid_q;
  logic signed [31:0] dist_d, dist_q;
  cell_t              cell_d, cell_q;

  always_comb begin
    zw     = $signed({3'b000, zone_width_i});
    lo_dist = 34'(y_low_edge_i) - 34'(y_lower_i);
    up_lim  = 34'(y_upper_i) - zw;
    d_lo    = 35'(y_center_i) + 35'(y_center_i) - 35'(y_low_edge_i) - 35'(y_lower_i);
    d_up    = 34'(y_upper_i) - 34'(y_low_edge_i);
    neg3y   = -(35'(y_center_i) + 35'(y_center_i) + 35'(y_center_i));

    cell_d.vx     = vel_x_i;
    cell_d.vy     = vel_y_i;
    cell_d.en     = energy_in_i;
    cell_d.rho    = density_in_i;
    cell_d.vx_ref = 33'(neg3y >>> 1);
    if (lo_dist < zw) begin
      cell_d.zone = ZONE_LOWER;
      dist_d      = sat32(48'(d_lo));
    end else if (34'(y_low_edge_i) > up_lim) begin
      cell_d.zone = ZONE_UPPER;
      dist_d      = sat32(48'(d_up));
    end else begin
      cell_d.zone = ZONE_NONE;
      dist_d      = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    dist_q <= dist_d;
    cell_q <= cell_d;
  end

  assign valid_o = valid_q;
  assign dist_o  = dist_q;
  assign cell_o  = cell_q;

endmodule

### rtl/bwd_ratio.sv
// Ratio stages: distance times reciprocal width, saturation, table index.
// Depends on bwd_pkg.
module bwd_ratio import bwd_pkg::*; #(
  parameter int unsigned MASK_TABLE_DEPTH = MASK_TABLE_DEPTH_DEF,
  localparam int unsigned IdxW = $clog2(MASK_TABLE_DEPTH)
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               valid_i,
  input  logic signed [31:0] dist_i,
  input  cell_t              cell_i,
  input  logic        [30:0] inv_zone_width_i,
  output logic               valid_o,
  output logic [IdxW-1:0]    idx_o,
  output cell_t              cell_o
);

  logic signed [63:0] prod_d, prod_q;
  logic signed [31:0] q_sat;
  logic        [29:0] scaled;
  logic [IdxW-1:0]    idx_q;
  logic               v1_q, v2_q;
  cell_t              c1_q, c2_q;

  always_comb begin
    prod_d = 64'(dist_i) * 64'($signed({1'b0, inv_zone_width_i}));
    q_sat  = sat32(48'(prod_q >>> 16));
    scaled = 30'(q_sat[16:0]) * 30'(MASK_TABLE_DEPTH);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
    end else begin
      v1_q <= valid_i;
      v2_q <= v1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    prod_q <= prod_d;
    c1_q   <= cell_i;
    idx_q  <= scaled[17 +: IdxW];
    c2_q   <= c1_q;
  end

  assign valid_o = v2_q;
  assign idx_o   = idx_q;
  assign cell_o  = c2_q;

endmodule

### rtl/bwd_mask_rom.sv
// Sine-squared mask table, built at elaboration, read through a register.
// Depends on bwd_pkg.
module bwd_mask_rom import bwd_pkg::*; #(
  parameter int unsigned MASK_TABLE_DEPTH = MASK_TABLE_DEPTH_DEF,
  localparam int unsigned IdxW = $clog2(MASK_TABLE_DEPTH)
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              valid_i,
  input  logic [IdxW-1:0]   idx_i,
  input  cell_t             cell_i,
  output logic              valid_o,
  output logic [MASK_W-1:0] mask_o,
  output cell_t             cell_o
);

  function automatic logic [MASK_W-1:0] mask_entry(input int unsigned idx);
    longint unsigned num, u, x, x2, t, s2, r;
    longint          s;
    if (2 * idx <= MASK_TABLE_DEPTH) begin
      num = 64'(2 * idx);
    end else begin
      num = 64'(2 * MASK_TABLE_DEPTH - 2 * idx);
    end
    u  = (num << 30) / 64'(MASK_TABLE_DEPTH);
    x  = (u * HALF_PI_Q30) >> 30;
    x2 = (x * x) >> 30;
    t  = x;
    s  = longint'(x);
    for (int k = 1; k <= 7; k++) begin
      t = ((t * x2) >> 30) / TAYLOR_DIV[k];
      if (k % 2 == 1) begin
        s = s - longint'(t);
      end else begin
        s = s + longint'(t);
      end
    end
    if (s < 0) begin
      s = 0;
    end
    if (s > longint'(ONE_Q30)) begin
      s = longint'(ONE_Q30);
    end
    s2 = (longint'(s) * longint'(s)) >> 30;
    r  = (s2 * BETA_Q32 + (64'd1 << 45)) >> 46;
    return r[MASK_W-1:0];
  endfunction

  logic [MASK_W-1:0] rom [MASK_TABLE_DEPTH];
  logic [MASK_W-1:0] mask_q;
  logic              valid_q;
  cell_t             cell_q;

  for (genvar gi = 0; gi < MASK_TABLE_DEPTH; gi++) begin : g_rom
    assign rom[gi] = mask_entry(gi);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    mask_q <= rom[idx_i];
    cell_q <= cell_i;
  end

  assign valid_o = valid_q;
  assign mask_o  = mask_q;
  assign cell_o  = cell_q;

endmodule

### rtl/bwd_damp.sv
// Damping stages: four lanes pulled toward their references by the mask.
// Depends on bwd_pkg.
module bwd_damp import bwd_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               valid_i,
  input  logic [MASK_W-1:0]  mask_i,
  input  cell_t              cell_i,
  input  logic signed [31:0] energy_ref_i,
  input  logic signed [31:0] density_ref_i,
  output logic               valid_o,
  output logic signed [31:0] vel_x_o,
  output logic signed [31:0] vel_y_o,
  output logic signed [31:0] energy_o,
  output logic signed [31:0] density_o,
  output zone_e              zone_o
);

  logic signed [31:0] val   [4];
  logic signed [34:0] refv  [4];
  logic signed [45:0] prod_d [4];
  logic signed [45:0] prod_q [4];
  logic signed [31:0] val_q [4];
  logic signed [31:0] res_d [4];
  logic signed [31:0] res_q [4];
  logic signed [45:0] term  [4];
  zone_e              zone_a_q, zone_b_q;
  logic               va_q, vb_q;

  always_comb begin
    val[0]  = cell_i.vx;
    val[1]  = cell_i.vy;
    val[2]  = cell_i.en;
    val[3]  = cell_i.rho;
    refv[0] = 35'(cell_i.vx_ref);
    refv[1] = '0;
    refv[2] = 35'(energy_ref_i);
    refv[3] = 35'(density_ref_i);
    for (int i = 0; i < 4; i++) begin
      prod_d[i] = 46'(35'(val[i]) - refv[i]) * 46'($signed({1'b0, mask_i}));
      term[i]   = (prod_q[i] + 46'sd32768) >>> 16;
      if (zone_a_q == ZONE_NONE) begin
        res_d[i] = val_q[i];
      end else begin
        res_d[i] = sat32(48'(val_q[i]) - 48'(term[i]));
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      va_q <= 1'b0;
      vb_q <= 1'b0;
    end else begin
      va_q <= valid_i;
      vb_q <= va_q;
    end
  end

  always_ff @(posedge clk_i) begin
    zone_a_q <= cell_i.zone;
    zone_b_q <= zone_a_q;
    for (int i = 0; i < 4; i++) begin
      prod_q[i] <= prod_d[i];
      val_q[i]  <= val[i];
      res_q[i]  <= res_d[i];
    end
  end

  assign valid_o   = vb_q;
  assign vel_x_o   = res_q[0];
  assign vel_y_o   = res_q[1];
  assign energy_o  = res_q[2];
  assign density_o = res_q[3];
  assign zone_o    = zone_b_q;

endmodule

### rtl/boundary_wave_damping_cell.sv
// Boundary wave damping cell, top level: configuration registers and pipeline.
// Depends on bwd_pkg, bwd_zone, bwd_ratio, bwd_mask_rom and bwd_damp.
//
// Usage:
//   A cell word is taken at each rising edge with start high and busy low.
//   busy stays low, so one cell word enters every clock cycle.
//   The result word shows on the *_out_o ports and zone_hit_o for exactly
//   one cycle with out_valid_o high, after the cell has passed every
//   register stage listed below. Results leave in the order cells came.
//   The pipeline has six register stages: zone test, width multiply,
//   ratio saturation and table index, mask table read, damping multiply,
//   output saturation. The 32x31 width multiply sets the stage depth.
//   Configuration writes (cfg_we_i, cfg_idx_i, cfg_wdata_i) take effect at
//   the next edge; indexes beyond the register list are dropped. Write only
//   while no cell is in flight.
//   Reset clears the pipeline valid bits and loads the default registers;
//   there is no clearing pass. The receiver cannot stall the output.
module boundary_wave_damping_cell import bwd_pkg::*; #(
  parameter int unsigned MASK_TABLE_DEPTH = MASK_TABLE_DEPTH_DEF
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start,
  output logic               busy,
  input  logic signed [31:0] y_center_i,
  input  logic signed [31:0] y_low_edge_i,
  input  logic signed [31:0] vel_x_i,
  input  logic signed [31:0] vel_y_i,
  input  logic signed [31:0] energy_in_i,
  input  logic signed [31:0] density_in_i,
  input  logic               cfg_we_i,
  input  logic [2:0]         cfg_idx_i,
  input  logic [31:0]        cfg_wdata_i,
  output logic               out_valid_o,
  output logic signed [31:0] vel_x_out_o,
  output logic signed [31:0] vel_y_out_o,
  output logic signed [31:0] energy_out_o,
  output logic signed [31:0] density_out_o,
  output logic [1:0]         zone_hit_o
);

  localparam int unsigned IdxW = $clog2(MASK_TABLE_DEPTH);

  logic signed [31:0] y_lower_q, y_upper_q, density_ref_q, energy_ref_q;
  logic        [30:0] zone_w_q, inv_zone_w_q;

  logic               z_valid, r_valid, m_valid;
  logic signed [31:0] z_dist;
  cell_t              z_cell, r_cell, m_cell;
  logic [IdxW-1:0]    r_idx;
  logic [MASK_W-1:0]  m_mask;
  zone_e              zone_out;

  assign busy = 1'b0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      y_lower_q     <= Y_LOWER_RST;
      y_upper_q     <= Y_UPPER_RST;
      zone_w_q      <= ZONE_W_RST;
      inv_zone_w_q  <= INV_ZONE_W_RST;
      density_ref_q <= DENSITY_REF_RST;
      energy_ref_q  <= ENERGY_REF_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_idx_i))
        CFG_Y_LOWER:     y_lower_q     <= cfg_wdata_i;
        CFG_Y_UPPER:     y_upper_q     <= cfg_wdata_i;
        CFG_ZONE_W:      zone_w_q      <= cfg_wdata_i[30:0];
        CFG_INV_ZONE_W:  inv_zone_w_q  <= cfg_wdata_i[30:0];
        CFG_DENSITY_REF: density_ref_q <= cfg_wdata_i;
        CFG_ENERGY_REF:  energy_ref_q  <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  bwd_zone u_zone (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .valid_i      (start & ~busy),
    .y_center_i   (y_center_i),
    .y_low_edge_i (y_low_edge_i),
    .vel_x_i      (vel_x_i),
    .vel_y_i      (vel_y_i),
    .energy_in_i  (energy_in_i),
    .density_in_i (density_in_i),
    .y_lower_i    (y_lower_q),
    .y_upper_i    (y_upper_q),
    .zone_width_i (zone_w_q),
    .valid_o      (z_valid),
    .dist_o       (z_dist),
    .cell_o       (z_cell)
  );

  bwd_ratio #(
    .MASK_TABLE_DEPTH (MASK_TABLE_DEPTH)
  ) u_ratio (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .valid_i          (z_valid),
    .dist_i           (z_dist),
    .cell_i           (z_cell),
    .inv_zone_width_i (inv_zone_w_q),
    .valid_o          (r_valid),
    .idx_o            (r_idx),
    .cell_o           (r_cell)
  );

  bwd_mask_rom #(
    .MASK_TABLE_DEPTH (MASK_TABLE_DEPTH)
  ) u_rom (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (r_valid),
    .idx_i   (r_idx),
    .cell_i  (r_cell),
    .valid_o (m_valid),
    .mask_o  (m_mask),
    .cell_o  (m_cell)
  );

  bwd_damp u_damp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .valid_i       (m_valid),
    .mask_i        (m_mask),
    .cell_i        (m_cell),
    .energy_ref_i  (energy_ref_q),
    .density_ref_i (density_ref_q),
    .valid_o       (out_valid_o),
    .vel_x_o       (vel_x_out_o),
    .vel_y_o       (vel_y_out_o),
    .energy_o      (energy_out_o),
    .density_o     (density_out_o),
    .zone_o        (zone_out)
  );

  assign zone_hit_o = 2'(zone_out);

endmodule

### rtl/bwd_checker.sv
// Port-level checker for the boundary wave damping cell, bound to the top.
// Depends on bwd_pkg and boundary_wave_damping_cell.
module bwd_checker import bwd_pkg::*; (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               start,
  input logic               busy,
  input logic signed [31:0] vel_x_i,
  input logic signed [31:0] vel_y_i,
  input logic signed [31:0] energy_in_i,
  input logic signed [31:0] density_in_i,
  input logic               out_valid_o,
  input logic signed [31:0] vel_x_out_o,
  input logic signed [31:0] vel_y_out_o,
  input logic signed [31:0] energy_out_o,
  input logic signed [31:0] density_out_o,
  input logic [1:0]         zone_hit_o
);

  a_result_has_word: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> $past(start && !busy, 6))
    else $error("result without an accepted word");

  a_word_gives_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |-> ##6 out_valid_o)
    else $error("accepted word gave no result");

  a_zone_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> zone_hit_o != 2'd3)
    else $error("bad zone code");

  a_pass_through: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && zone_hit_o == 2'(ZONE_NONE)) |->
      (vel_x_out_o == $past(vel_x_i, 6) && vel_y_out_o == $past(vel_y_i, 6) &&
       energy_out_o == $past(energy_in_i, 6) &&
       density_out_o == $past(density_in_i, 6)))
    else $error("cell outside the zones was altered");

endmodule

bind boundary_wave_damping_cell bwd_checker u_bwd_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .start         (start),
  .busy          (busy),
  .vel_x_i       (vel_x_i),
  .vel_y_i       (vel_y_i),
  .energy_in_i   (energy_in_i),
  .density_in_i  (density_in_i),
  .out_valid_o   (out_valid_o),
  .vel_x_out_o   (vel_x_out_o),
  .vel_y_out_o   (vel_y_out_o),
  .energy_out_o  (energy_out_o),
  .density_out_o (density_out_o),
  .zone_hit_o    (zone_hit_o)
);

### test/tb.sv
// Self-checking testbench for boundary_wave_damping_cell: damps random and corner-case cells
// under several register settings and compares every result word with a built-in predictor.
// Depends on bwd_pkg and the RTL of the block.
module tb import bwd_pkg::*;;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int PIPE_LAT = 6;
  localparam int LUT_DEPTH = MASK_TABLE_DEPTH_DEF;
  localparam longint LUT_PI_HALF = 64'd1686629713;
  localparam longint LUT_ONE = 64'd1073741824;
  localparam longint LUT_BETA = 64'd34359738;
  localparam int I32_MAX = 32'sh7fffffff;
  localparam int I32_MIN = 32'sh80000000;
  localparam logic [2:0] CFG_SPARE_6 = 3'd6;
  localparam logic [2:0] CFG_SPARE_7 = 3'd7;

  typedef struct {
    int yc;
    int yl;
    int vx;
    int vy;
    int en;
    int rho;
  } cell_t;

  typedef struct {
    logic [31:0] vx;
    logic [31:0] vy;
    logic [31:0] en;
    logic [31:0] rho;
    logic [1:0]  zone;
  } damped_t;

  function automatic longint clip32(longint v);
    if (v > longint'(I32_MAX)) begin
      return longint'(I32_MAX);
    end else if (v < longint'(I32_MIN)) begin
      return longint'(I32_MIN);
    end
    return v;
  endfunction

  class damp_board;
    longint y_lo, y_hi, zw, inv_zw, rho_ref, en_ref;
    longint sin2_lut[LUT_DEPTH];
    damped_t damped_q[$];
    int failures;

    function new();
      longint num, u, x, x2, t, s, s2;
      y_lo = 0;
      y_hi = 65536;
      zw = 6554;
      inv_zw = 655360;
      rho_ref = 65536;
      en_ref = 65536;
      failures = 0;
      for (int i = 0; i < LUT_DEPTH; i++) begin
        num = (2 * i <= LUT_DEPTH) ? 2 * i : 2 * LUT_DEPTH - 2 * i;
        u = (num << 30) / LUT_DEPTH;
        x = (u * LUT_PI_HALF) >> 30;
        x2 = (x * x) >> 30;
        t = x;
        s = x;
        for (int k = 1; k <= 7; k++) begin
          t = ((t * x2) >> 30) / ((2 * k) * (2 * k + 1));
          if (k % 2 == 1) begin
            s = s - t;
          end else begin
            s = s + t;
          end
        end
        if (s < 0) s = 0;
        if (s > LUT_ONE) s = LUT_ONE;
        s2 = (s * s) >> 30;
        sin2_lut[i] = (s2 * LUT_BETA + (64'd1 << 45)) >> 46;
      end
    endfunction

    function void set_reg(logic [2:0] idx, logic [31:0] data);
      case (idx)
        CFG_Y_LOWER:     y_lo = longint'($signed(data));
        CFG_Y_UPPER:     y_hi = longint'($signed(data));
        CFG_ZONE_W:      zw = longint'(data[30:0]);
        CFG_INV_ZONE_W:  inv_zw = longint'(data[30:0]);
        CFG_DENSITY_REF: rho_ref = longint'($signed(data));
        CFG_ENERGY_REF:  en_ref = longint'($signed(data));
        default: ;
      endcase
    endfunction

    function longint pull(longint v, longint anchor, longint m);
      return clip32(v - ((m * (v - anchor) + 32768) >>> 16));
    endfunction

    function damped_t damp_cell(cell_t c);
      longint yc = c.yc;
      longint yl = c.yl;
      longint d = 0;
      longint q, idx, m;
      zone_e z = ZONE_NONE;
      damped_t r;
      if (yl - y_lo < zw) begin
        z = ZONE_LOWER;
        d = clip32(2 * yc - yl - y_lo);
      end else if (yl > y_hi - zw) begin
        z = ZONE_UPPER;
        d = clip32(y_hi - yl);
      end
      r.vx = c.vx;
      r.vy = c.vy;
      r.en = c.en;
      r.rho = c.rho;
      if (z != ZONE_NONE) begin
        q = clip32((d * inv_zw) >>> 16);
        idx = ((q & 64'h1FFFF) * LUT_DEPTH) >> 17;
        m = sin2_lut[idx];
        r.vx = 32'(pull(c.vx, (-3 * yc) >>> 1, m));
        r.vy = 32'(pull(c.vy, 0, m));
        r.en = 32'(pull(c.en, en_ref, m));
        r.rho = 32'(pull(c.rho, rho_ref, m));
      end
      r.zone = z;
      return r;
    endfunction

    function void note_cell(cell_t c);
      damped_q.push_back(damp_cell(c));
    endfunction

    function void flag(string what, damped_t want, damped_t got);
      failures++;
      if (failures <= 10) begin
        $display("%0t %s: want vx=%0d vy=%0d en=%0d rho=%0d zone=%0d", $realtime, what,
                 $signed(want.vx), $signed(want.vy), $signed(want.en), $signed(want.rho),
                 want.zone);
        $display("%0t %s: got  vx=%0d vy=%0d en=%0d rho=%0d zone=%0d", $realtime, what,
                 $signed(got.vx), $signed(got.vy), $signed(got.en), $signed(got.rho),
                 got.zone);
      end
    endfunction

    function void check_word(damped_t got);
      damped_t want;
      if (damped_q.size() == 0) begin
        flag("unexpected word", want, got);
        return;
      end
      want = damped_q.pop_front();
      if (got.vx !== want.vx || got.vy !== want.vy || got.en !== want.en ||
          got.rho !== want.rho || got.zone !== want.zone) begin
        flag("mismatch", want, got);
      end
    endfunction

    function int pending();
      return damped_q.size();
    endfunction

    function void close();
      damped_t none;
      while (damped_q.size() > 0) begin
        flag("missing word", damped_q.pop_front(), none);
      end
    endfunction
  endclass

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic start = 1'b0;
  logic busy;
  logic signed [31:0] y_center_i = '0;
  logic signed [31:0] y_low_edge_i = '0;
  logic signed [31:0] vel_x_i = '0;
  logic signed [31:0] vel_y_i = '0;
  logic signed [31:0] energy_in_i = '0;
  logic signed [31:0] density_in_i = '0;
  logic cfg_we_i = 1'b0;
  logic [2:0] cfg_idx_i = '0;
  logic [31:0] cfg_wdata_i = '0;
  logic out_valid_o;
  logic signed [31:0] vel_x_out_o, vel_y_out_o, energy_out_o, density_out_o;
  logic [1:0] zone_hit_o;

  damp_board board;
  bit start_lvl = 1'b0;
  bit burst = 1'b0;

  boundary_wave_damping_cell i_dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .start        (start),
    .busy         (busy),
    .y_center_i   (y_center_i),
    .y_low_edge_i (y_low_edge_i),
    .vel_x_i      (vel_x_i),
    .vel_y_i      (vel_y_i),
    .energy_in_i  (energy_in_i),
    .density_in_i (density_in_i),
    .cfg_we_i     (cfg_we_i),
    .cfg_idx_i    (cfg_idx_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .out_valid_o  (out_valid_o),
    .vel_x_out_o  (vel_x_out_o),
    .vel_y_out_o  (vel_y_out_o),
    .energy_out_o (energy_out_o),
    .density_out_o(density_out_o),
    .zone_hit_o   (zone_hit_o)
  );

  always #5 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cell_t c;
    damped_t got;
    if (rst_ni) begin
      if (start && !busy) begin
        c.yc = y_center_i;
        c.yl = y_low_edge_i;
        c.vx = vel_x_i;
        c.vy = vel_y_i;
        c.en = energy_in_i;
        c.rho = density_in_i;
        board.note_cell(c);
      end
      if (out_valid_o) begin
        got.vx = vel_x_out_o;
        got.vy = vel_y_out_o;
        got.en = energy_out_o;
        got.rho = density_out_o;
        got.zone = zone_hit_o;
        board.check_word(got);
      end
    end
  end

  function automatic cell_t mk(int yc, int yl, int vx, int vy, int en, int rho);
    cell_t c;
    c.yc = yc;
    c.yl = yl;
    c.vx = vx;
    c.vy = vy;
    c.en = en;
    c.rho = rho;
    return c;
  endfunction

  function automatic int rand_field(longint anchor);
    case ($urandom_range(0, 3))
      1: return int'(clip32(clip32(anchor) + longint'($urandom_range(0, 2 ** 21)) - 2 ** 20));
      2: return $urandom_range(0, 1) ? I32_MAX : I32_MIN;
      default: return $urandom;
    endcase
  endfunction

  function automatic cell_t random_cell();
    cell_t c;
    longint w, off, yl, yc;
    int pick;
    w = (board.zw < 16) ? 16 : board.zw;
    pick = $urandom_range(0, 9);
    off = longint'($urandom_range(0, 32'(2 * w))) - w / 2;
    if (pick < 8) begin
      yl = (pick < 4) ? board.y_lo + off : board.y_hi - w + off;
      yl = clip32(yl);
      yc = clip32(yl + longint'($urandom_range(0, 32'(w))));
      c.yl = int'(yl);
      c.yc = int'(yc);
    end else begin
      c.yl = $urandom;
      c.yc = $urandom;
    end
    c.vx = rand_field((-3 * longint'(c.yc)) >>> 1);
    c.vy = rand_field(0);
    c.en = rand_field(board.en_ref);
    c.rho = rand_field(board.rho_ref);
    return c;
  endfunction

  task automatic set_start(bit v);
    if (start_lvl != v) begin
      start <= v;
      start_lvl = v;
    end
  endtask

  task automatic push_cell(cell_t c);
    set_start(1'b1);
    y_center_i <= c.yc;
    y_low_edge_i <= c.yl;
    vel_x_i <= c.vx;
    vel_y_i <= c.vy;
    energy_in_i <= c.en;
    density_in_i <= c.rho;
    do @(posedge clk_i); while (busy);
  endtask

  task automatic idle(int gap);
    if (gap > 0) begin
      set_start(1'b0);
      repeat (gap) @(posedge clk_i);
    end
  endtask

  task automatic drain();
    set_start(1'b0);
    while (board.pending() > 0) @(posedge clk_i);
    repeat (PIPE_LAT + 2) @(posedge clk_i);
  endtask

  task automatic write_reg(logic [2:0] idx, logic [31:0] data);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_wdata_i <= data;
    @(posedge clk_i);
    board.set_reg(idx, data);
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic apply_cfg(int lo, int hi, logic [31:0] zwv, logic [31:0] inv, int rho_r,
                           int en_r);
    write_reg(CFG_Y_LOWER, lo);
    write_reg(CFG_Y_UPPER, hi);
    write_reg(CFG_ZONE_W, zwv);
    write_reg(CFG_INV_ZONE_W, inv);
    write_reg(CFG_DENSITY_REF, rho_r);
    write_reg(CFG_ENERGY_REF, en_r);
    write_reg(CFG_SPARE_6, $urandom);
    write_reg(CFG_SPARE_7, $urandom);
  endtask

  task automatic run_list(cell_t cells[$]);
    foreach (cells[i]) begin
      push_cell(cells[i]);
      idle($urandom_range(0, 7));
    end
    drain();
  endtask

  task automatic run_directed();
    cell_t dq[$];
    dq.push_back(mk(0, 0, 0, 0, 0, 0));
    dq.push_back(mk(1638, 0, 65536, -65536, 196608, 0));
    dq.push_back(mk(6554, 3277, -131072, 98304, -65536, 327680));
    dq.push_back(mk(6553, 6553, 1000, -1000, 70000, 60000));
    dq.push_back(mk(6554, 6554, 1000, -1000, 70000, 60000));
    dq.push_back(mk(58982, 58982, 5, 6, 7, 8));
    dq.push_back(mk(60000, 58983, 65536, 65536, 0, 0));
    dq.push_back(mk(63897, 62259, -65536, 131072, 131072, -131072));
    dq.push_back(mk(65536, 65536, 12345, -12345, 54321, -54321));
    dq.push_back(mk(I32_MAX, I32_MIN, I32_MAX, I32_MIN, I32_MAX, I32_MIN));
    dq.push_back(mk(I32_MIN, I32_MAX, I32_MIN, I32_MAX, I32_MIN, I32_MAX));
    dq.push_back(mk(20000, 0, I32_MIN, I32_MAX, I32_MIN, I32_MAX));
    dq.push_back(mk(I32_MIN, 3277, I32_MAX, 0, 65536, 65536));
    dq.push_back(mk(30000, 30000, I32_MIN, I32_MAX, I32_MIN, I32_MAX));
    dq.push_back(mk(-1, 30000, -1, -1, -1, -1));
    run_list(dq);

    apply_cfg(0, 65536, 49152, 87381, -65536, 0);
    dq.delete();
    dq.push_back(mk(31000, 30000, 65536, -65536, 65536, 65536));
    dq.push_back(mk(52000, 50000, 65536, 65536, -65536, 0));
    dq.push_back(mk(-500, -1000, 1, 2, 3, 4));
    dq.push_back(mk(70000, 70000, -65536, 65536, I32_MAX, I32_MIN));
    run_list(dq);

    apply_cfg(0, 65536, 0, 655360, I32_MAX, I32_MIN);
    dq.delete();
    dq.push_back(mk(-1, -1, 100, 200, 300, 400));
    dq.push_back(mk(0, 0, 100, 200, 300, 400));
    dq.push_back(mk(65536, 65536, 100, 200, 300, 400));
    dq.push_back(mk(65537, 65537, I32_MAX, I32_MIN, 0, 0));
    run_list(dq);
  endtask

  task automatic run_random(int n);
    for (int i = 0; i < n; i++) begin
      if (i % 64 == 0) burst = ($urandom_range(0, 3) == 0);
      push_cell(random_cell());
      idle(burst ? 0 : $urandom_range(0, 7));
    end
    drain();
  endtask

  initial begin
    board = new();
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    run_directed();

    apply_cfg(0, 65536, 6554, 655360, 65536, 65536);
    run_random(125);
    apply_cfg(-5 * 65536, 5 * 65536, 2 * 65536, 32768, 3 * 65536, -2 * 65536);
    run_random(125);
    apply_cfg(I32_MIN, I32_MAX, 32'h7fffffff, 32'h7fffffff, I32_MAX, I32_MIN);
    run_random(125);
    apply_cfg(I32_MAX, I32_MIN, 32'h0, 32'h0, I32_MIN, I32_MAX);
    run_random(125);
    apply_cfg(-65536, 65536, 65536, 32'h7fffffff, 0, 65536);
    run_random(125);
    repeat (2) begin
      apply_cfg($urandom, $urandom, $urandom, $urandom, $urandom, $urandom);
      run_random(125);
    end

    drain();
    board.close();
    if (board.failures == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("Regression FAIL");
    $finish;
  end

endmodule
